@@ design/gps_pkg.sv @@
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types and constants for the glitch pulse sequencer: item structs,
// command byte values, command kinds and reset values.
// ----------------------------------------------------------------------------
package gps_pkg;

	// Command bytes
	localparam logic [7:0] CMD_LOAD_DELAY = 8'h44;  // 'D'
	localparam logic [7:0] CMD_LOAD_PULSE = 8'h50;  // 'P'
	localparam logic [7:0] CMD_START      = 8'h47;  // 'G'

	// Reset values
	localparam logic [31:0] COUNT_RESET     = 32'd10000;
	localparam logic [31:0] POWER_OFF_RESET = 32'd6250000;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Command kind found by the front end
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_DELAY = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD_PULSE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_START      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OTHER      = 3'd4;

	typedef struct packed {
		logic       byte_present;
		logic [7:0] data_byte;
		logic       trigger_level;
	} in_item_t;

	typedef struct packed {
		logic power_disable;
		logic glitch_out;
		logic byte_taken;
		logic busy_res;
	} out_item_t;

	// Classified item held in the queue
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        data_byte;
		logic              trigger_level;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ design/glitch_pulse_sequencer.sv @@
// ----------------------------------------------------------------------------
// glitch_pulse_sequencer
// Glitch timing block: command byte parser and power / trigger / delay / pulse
// sequencer, one clock tick of the glitch timer per input item.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    in_item   (byte_present, data_byte, trigger_level)
//  out       out_valid / out_ready  out_item  (power_disable, glitch_out, byte_taken,
//                                              busy_res)
//  cfg       cfg_valid / cfg_ready  cfg_data  (power_off_ticks, always ready)
//
//  One item per cycle sustained while the output is not stalled; an accepted
//  item passes through the front register, the queue and the sequencer output
//  register, in that order, before its result is valid.
//  The sequencer updates its parse and sequence state once per popped item.
//  Reset: power off, delay and pulse 10000 ticks, power_off_ticks 6250000.
//  A stalled output fills the queue, then in_ready drops; no item is lost.
// ----------------------------------------------------------------------------
module glitch_pulse_sequencer #(
	parameter int QUEUE_DEPTH = gps_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  gps_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output gps_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);

	logic               push;
	gps_pkg::q_entry_t  push_entry;
	logic               pop;
	logic               head_valid;
	gps_pkg::q_entry_t  head_entry;
	gps_pkg::q_status_t q_status;

	gps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	gps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.status     (q_status)
	);

	gps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_status.full)
		else $error("input stalled while queue has room");

	a_glitch_with_power: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.glitch_out) |-> (!out_item.power_disable && out_item.busy_res))
		else $error("glitch driven outside a powered sequence");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.full && !pop) |=> !q_status.empty)
		else $error("full queue lost entries without a pop");

endmodule

@@ design/gps_front.sv @@
// ----------------------------------------------------------------------------
// gps_front
// Input stage: registers each item and tags it with its command kind, then
// pushes it into the queue.
// ----------------------------------------------------------------------------
module gps_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gps_pkg::in_item_t   in_item,
	input  gps_pkg::q_status_t  q_status,
	output logic                push,
	output gps_pkg::q_entry_t   push_entry
);

	logic                       valid_s1;
	gps_pkg::q_entry_t          entry_s1;
	logic [gps_pkg::KIND_W-1:0] kind;

	always_comb begin
		priority if (!in_item.byte_present) begin
			kind = gps_pkg::KIND_NONE;
		end else if (in_item.data_byte == gps_pkg::CMD_LOAD_DELAY) begin
			kind = gps_pkg::KIND_LOAD_DELAY;
		end else if (in_item.data_byte == gps_pkg::CMD_LOAD_PULSE) begin
			kind = gps_pkg::KIND_LOAD_PULSE;
		end else if (in_item.data_byte == gps_pkg::CMD_START) begin
			kind = gps_pkg::KIND_START;
		end else begin
			kind = gps_pkg::KIND_OTHER;
		end
	end

	assign push     = valid_s1 && !q_status.full;
	assign in_ready = !valid_s1 || !q_status.full;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1.kind          <= kind;
			entry_s1.data_byte     <= in_item.data_byte;
			entry_s1.trigger_level <= in_item.trigger_level;
		end
	end

endmodule

@@ design/gps_queue.sv @@
// ----------------------------------------------------------------------------
// gps_queue
// Small FIFO of classified items between the front end and the sequencer.
// ----------------------------------------------------------------------------
module gps_queue #(
	parameter int DEPTH = gps_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gps_pkg::q_entry_t   push_entry,
	input  logic                pop,
	output logic                head_valid,
	output gps_pkg::q_entry_t   head_entry,
	output gps_pkg::q_status_t  status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	gps_pkg::q_entry_t slots_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign status.full  = (count_q == FULL);
	assign status.empty = (count_q == '0);
	assign head_valid   = !status.empty;
	assign head_entry   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ design/gps_back.sv @@
// ----------------------------------------------------------------------------
// gps_back
// Sequencer: parses load commands, runs the power-off / trigger / delay /
// pulse sequence one tick per item and holds each result in an output register.
// ----------------------------------------------------------------------------
module gps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	input  logic               head_valid,
	input  gps_pkg::q_entry_t  head_entry,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output gps_pkg::out_item_t out_item
);

	localparam logic [1:0] PARSE_IDLE  = 2'd0;
	localparam logic [1:0] PARSE_DELAY = 2'd1;
	localparam logic [1:0] PARSE_PULSE = 2'd2;

	localparam logic [2:0] SEQ_IDLE      = 3'd0;
	localparam logic [2:0] SEQ_POWER_OFF = 3'd1;
	localparam logic [2:0] SEQ_WAIT_TRIG = 3'd2;
	localparam logic [2:0] SEQ_DELAY     = 3'd3;
	localparam logic [2:0] SEQ_PULSE     = 3'd4;

	logic [31:0] off_len_q;
	logic [1:0]  parse_q, parse_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [23:0] word_q, word_d;
	logic [31:0] delay_q, delay_d;
	logic [31:0] pulse_q, pulse_d;
	logic [2:0]  seq_q, seq_d;
	logic [31:0] tick_q, tick_d;
	logic        pwr_off_q, pwr_off_d;
	logic        taken;
	logic [31:0] tick_inc;

	logic               out_valid_q;
	gps_pkg::out_item_t out_item_q;

	assign cfg_ready = 1'b1;
	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign tick_inc  = tick_q + 32'd1;

	always_comb begin
		parse_d   = parse_q;
		cnt_d     = cnt_q;
		word_d    = word_q;
		delay_d   = delay_q;
		pulse_d   = pulse_q;
		seq_d     = seq_q;
		tick_d    = tick_q;
		pwr_off_d = pwr_off_q;
		taken     = 1'b0;

		if (seq_q != SEQ_IDLE) begin
			// busy: advance the sequence, drop any byte
			unique case (seq_q)
				SEQ_POWER_OFF: begin
					if (tick_inc >= off_len_q) begin
						pwr_off_d = 1'b0;
						seq_d     = SEQ_WAIT_TRIG;
						tick_d    = '0;
					end else begin
						tick_d = tick_inc;
					end
				end
				SEQ_WAIT_TRIG: begin
					if (head_entry.trigger_level) begin
						seq_d  = SEQ_DELAY;
						tick_d = '0;
					end
				end
				SEQ_DELAY: begin
					if (tick_q < delay_q) begin
						tick_d = tick_inc;
					end else if (pulse_q != '0) begin
						// first pulse tick counts in the same step
						seq_d  = SEQ_PULSE;
						tick_d = 32'd1;
					end else begin
						seq_d  = SEQ_IDLE;
						tick_d = '0;
					end
				end
				SEQ_PULSE: begin
					if (tick_q < pulse_q) begin
						tick_d = tick_inc;
					end else begin
						seq_d  = SEQ_IDLE;
						tick_d = '0;
					end
				end
				default: begin
					seq_d = seq_q;
				end
			endcase
		end else if (head_entry.kind != gps_pkg::KIND_NONE) begin
			taken = 1'b1;
			if (parse_q == PARSE_DELAY || parse_q == PARSE_PULSE) begin
				// raw data byte, little-endian
				cnt_d = cnt_q + 2'd1;
				unique case (cnt_q)
					2'd0: word_d[7:0]   = head_entry.data_byte;
					2'd1: word_d[15:8]  = head_entry.data_byte;
					2'd2: word_d[23:16] = head_entry.data_byte;
					default: begin
						if (parse_q == PARSE_DELAY) begin
							delay_d = {head_entry.data_byte, word_q};
						end else begin
							pulse_d = {head_entry.data_byte, word_q};
						end
						word_d  = '0;
						parse_d = PARSE_IDLE;
					end
				endcase
			end else begin
				parse_d = PARSE_IDLE;
				unique case (head_entry.kind)
					gps_pkg::KIND_LOAD_DELAY: begin
						parse_d = PARSE_DELAY;
						cnt_d   = '0;
						word_d  = '0;
					end
					gps_pkg::KIND_LOAD_PULSE: begin
						parse_d = PARSE_PULSE;
						cnt_d   = '0;
						word_d  = '0;
					end
					gps_pkg::KIND_START: begin
						seq_d     = SEQ_POWER_OFF;
						tick_d    = '0;
						pwr_off_d = 1'b1;
					end
					default: begin
						parse_d = PARSE_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_len_q   <= gps_pkg::POWER_OFF_RESET;
			parse_q     <= PARSE_IDLE;
			cnt_q       <= '0;
			word_q      <= '0;
			delay_q     <= gps_pkg::COUNT_RESET;
			pulse_q     <= gps_pkg::COUNT_RESET;
			seq_q       <= SEQ_IDLE;
			tick_q      <= '0;
			pwr_off_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				// zero length acts as one tick
				off_len_q <= (cfg_data == '0) ? 32'd1 : cfg_data;
			end
			if (pop) begin
				parse_q     <= parse_d;
				cnt_q       <= cnt_d;
				word_q      <= word_d;
				delay_q     <= delay_d;
				pulse_q     <= pulse_d;
				seq_q       <= seq_d;
				tick_q      <= tick_d;
				pwr_off_q   <= pwr_off_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q.power_disable <= pwr_off_d;
			out_item_q.glitch_out    <= (seq_d == SEQ_PULSE);
			out_item_q.byte_taken    <= taken;
			out_item_q.busy_res      <= (seq_d != SEQ_IDLE);
		end
	end

endmodule

@@ verif/tb_glitch_pulse_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_glitch_pulse_sequencer
// Self-checking bench for the glitch pulse sequencer. A directed table covers
// command parsing, delay/width loads and start bytes taken as load data.
// Random phases with glitch runs and dropped bytes under several power-off
// lengths and idle patterns follow.
// Every tick is predicted in the bench and compared with the output item.
// ----------------------------------------------------------------------------
module tb_glitch_pulse_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT           = 400000;
	localparam int HOLD_CYCLES     = 300;
	localparam int SHORT_MAX       = 40;
	localparam int TICKS_PER_PHASE = 330;
	localparam int N_PHASES        = 6;
	localparam int N_DIR           = 32;

	localparam logic ROW_TICK  = 1'b0;
	localparam logic ROW_CFG   = 1'b1;
	localparam logic CHK_PRED  = 1'b0;
	localparam logic CHK_FIXED = 1'b1;

	localparam gps_pkg::out_item_t RES_NONE      = '{1'b0, 1'b0, 1'b0, 1'b0};
	localparam gps_pkg::out_item_t RES_OFF_IDLE  = '{1'b1, 1'b0, 1'b0, 1'b0};
	localparam gps_pkg::out_item_t RES_OFF_TAKEN = '{1'b1, 1'b0, 1'b1, 1'b0};

	localparam logic [31:0] OFF_LEN_PLAN [N_PHASES] = '{
		32'd1, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd5
	};

	typedef enum logic [1:0] {CM_IDLE, CM_LOAD_DLY, CM_LOAD_WID} cmd_mode_e;
	typedef enum logic [2:0] {
		SQ_IDLE, SQ_PWR_OFF, SQ_WAIT_TRIG, SQ_HOLDOFF, SQ_GLITCH
	} seq_e;

	typedef struct packed {
		logic               is_cfg;
		logic [31:0]        cfg_val;
		gps_pkg::in_item_t  item;
		logic               fixed;
		gps_pkg::out_item_t res;
	} dir_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	gps_pkg::in_item_t  in_item   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	gps_pkg::out_item_t out_item;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [31:0]        cfg_data  = '0;

	// bench copy of the block state
	logic [31:0] off_len_reg  = gps_pkg::POWER_OFF_RESET;
	cmd_mode_e   cmd_mode     = CM_IDLE;
	logic [1:0]  load_idx     = '0;
	logic [31:0] load_acc     = '0;
	logic [31:0] glitch_delay = gps_pkg::COUNT_RESET;
	logic [31:0] glitch_width = gps_pkg::COUNT_RESET;
	seq_e        seq_st       = SQ_IDLE;
	logic [31:0] seq_ticks    = '0;
	logic        tgt_off      = 1'b1;

	gps_pkg::out_item_t pending_levels [$];

	int snd_idle_pct  = 0;
	int rcv_idle_pct  = 0;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int cycles        = 0;
	int ticks_sent    = 0;
	int checked       = 0;
	int errors        = 0;
	int glitch_runs   = 0;
	int bytes_dropped = 0;
	int cfg_writes    = 0;

	string FIELD_NAMES [4] = '{"busy_res", "byte_taken", "glitch_out", "power_disable"};

	dir_row_t dir_tab [N_DIR] = '{
		'{ROW_TICK, 32'd0, '{1'b0, 8'hA5, 1'b1}, CHK_FIXED, RES_OFF_IDLE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b0}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, 8'hFF, 1'b1}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_LOAD_DELAY, 1'b0}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, 8'hFF, 1'b0}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, 8'hFF, 1'b1}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, 8'hFF, 1'b0}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, 8'hFF, 1'b1}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_LOAD_PULSE, 1'b0}, CHK_FIXED, RES_OFF_TAKEN},
		// start byte inside a load is plain data
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_START, 1'b1}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b0}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b0, gps_pkg::CMD_LOAD_DELAY, 1'b0}, CHK_FIXED, RES_OFF_IDLE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b0}, CHK_FIXED, RES_OFF_TAKEN},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b1}, CHK_FIXED, RES_OFF_TAKEN},
		// zero power-off length (taken as one tick), then delay and width loads
		'{ROW_CFG, 32'd0, '{1'b0, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_LOAD_DELAY, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h01, 1'b1}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b1}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_LOAD_PULSE, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b1}, CHK_PRED, RES_NONE},
		// pause mid-load, width must not change yet
		'{ROW_TICK, 32'd0, '{1'b0, 8'hFF, 1'b1}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_START, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_LOAD_DELAY, 1'b1}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b0, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, gps_pkg::CMD_START, 1'b1}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b0, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b0, 8'h00, 1'b0}, CHK_PRED, RES_NONE},
		'{ROW_TICK, 32'd0, '{1'b1, 8'h7E, 1'b1}, CHK_PRED, RES_NONE}
	};

	glitch_pulse_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Advance the bench state by one tick and return the output levels.
	function automatic gps_pkg::out_item_t predict_tick(input gps_pkg::in_item_t it);
		gps_pkg::out_item_t lv;
		logic [31:0]        off_len;
		logic               took;
		took    = 1'b0;
		off_len = (off_len_reg == '0) ? 32'd1 : off_len_reg;
		if (seq_st != SQ_IDLE) begin
			if (it.byte_present)
				bytes_dropped++;
			case (seq_st)
				SQ_PWR_OFF: begin
					seq_ticks = seq_ticks + 1;
					if (seq_ticks >= off_len) begin
						tgt_off   = 1'b0;
						seq_st    = SQ_WAIT_TRIG;
						seq_ticks = '0;
					end
				end
				SQ_WAIT_TRIG: begin
					if (it.trigger_level) begin
						seq_st    = SQ_HOLDOFF;
						seq_ticks = '0;
					end
				end
				SQ_HOLDOFF: begin
					if (seq_ticks < glitch_delay) begin
						seq_ticks = seq_ticks + 1;
					end else begin
						seq_st    = SQ_GLITCH;
						seq_ticks = '0;
					end
				end
				default: ;
			endcase
			// the tick that ends the hold-off already counts toward the pulse
			if (seq_st == SQ_GLITCH) begin
				if (seq_ticks < glitch_width) begin
					seq_ticks = seq_ticks + 1;
				end else begin
					seq_st    = SQ_IDLE;
					seq_ticks = '0;
				end
			end
		end else if (it.byte_present) begin
			took = 1'b1;
			if (cmd_mode != CM_IDLE) begin
				load_acc = load_acc | (32'(it.data_byte) << (8 * load_idx));
				load_idx = load_idx + 2'd1;
				if (load_idx == 2'd0) begin
					if (cmd_mode == CM_LOAD_DLY)
						glitch_delay = load_acc;
					else
						glitch_width = load_acc;
					load_acc = '0;
					cmd_mode = CM_IDLE;
				end
			end else if (it.data_byte == gps_pkg::CMD_LOAD_DELAY ||
			             it.data_byte == gps_pkg::CMD_LOAD_PULSE) begin
				cmd_mode = (it.data_byte == gps_pkg::CMD_LOAD_DELAY) ?
				           CM_LOAD_DLY : CM_LOAD_WID;
				load_idx = '0;
				load_acc = '0;
			end else if (it.data_byte == gps_pkg::CMD_START) begin
				seq_st    = SQ_PWR_OFF;
				seq_ticks = '0;
				tgt_off   = 1'b1;
				glitch_runs++;
			end
		end
		lv.power_disable = tgt_off;
		lv.glitch_out    = (seq_st == SQ_GLITCH);
		lv.byte_taken    = took;
		lv.busy_res      = (seq_st != SQ_IDLE);
		return lv;
	endfunction

	function automatic bit short_run_ok();
		return off_len_reg <= SHORT_MAX && glitch_delay <= SHORT_MAX &&
		       glitch_width <= SHORT_MAX;
	endfunction

	function automatic gps_pkg::in_item_t pick_tick(input int pct_present);
		gps_pkg::in_item_t it;
		it.byte_present  = ($urandom_range(99) < pct_present);
		it.trigger_level = ($urandom_range(99) < 25);
		case ($urandom_range(9))
			0:       it.data_byte = gps_pkg::CMD_LOAD_DELAY;
			1:       it.data_byte = gps_pkg::CMD_LOAD_PULSE;
			2:       it.data_byte = gps_pkg::CMD_START;
			default: it.data_byte = 8'($urandom);
		endcase
		// keep a long glitch run from starting by accident
		if (it.byte_present && seq_st == SQ_IDLE && cmd_mode == CM_IDLE &&
		    it.data_byte == gps_pkg::CMD_START && !short_run_ok())
			it.data_byte = it.data_byte ^ 8'h01;
		return it;
	endfunction

	task automatic send_tick(input gps_pkg::in_item_t it, input logic fixed = CHK_PRED,
	                         input gps_pkg::out_item_t res = RES_NONE);
		gps_pkg::out_item_t lv;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		lv = predict_tick(it);
		pending_levels.push_back(fixed ? res : lv);
		ticks_sent++;
	endtask

	task automatic send_load(input logic [7:0] cmd);
		logic [31:0]       v;
		gps_pkg::in_item_t it;
		v  = ($urandom_range(9) == 0) ? 32'($urandom_range(SHORT_MAX))
		                              : 32'($urandom_range(6));
		it = '{1'b1, cmd, 1'($urandom)};
		send_tick(it);
		for (int k = 0; k < 4; k++) begin
			if ($urandom_range(4) == 0)
				send_tick(pick_tick(0));
			it = '{1'b1, v[8*k +: 8], 1'($urandom)};
			send_tick(it);
		end
	endtask

	task automatic write_off_len(input logic [31:0] v);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid   <= 1'b0;
		off_len_reg = v;
		cfg_writes++;
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 30)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		gps_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending", checked));
			end else begin
				want = pending_levels.pop_front();
				for (int f = 3; f >= 0; f--)
					if (out_item[f] !== want[f])
						report_mismatch($sformatf("result %0d %s got %b want %b",
							checked, FIELD_NAMES[f], out_item[f], want[f]));
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_levels.size());
			$display("tb_glitch_pulse_sequencer: FAIL");
			$finish;
		end
	end

	initial begin
		int start_cnt;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		snd_idle_pct = 26;
		rcv_idle_pct = 69;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_off_len(dir_tab[i].cfg_val);
			else
				send_tick(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].res);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			snd_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 69 : 0;
			rcv_idle_pct = (ph < 2) ? 69 : (ph < 4) ? 26 : 0;
			write_off_len(OFF_LEN_PLAN[ph]);
			// stall the output long enough to back up the input
			if (ph == 4)
				hold_reqs++;
			start_cnt = ticks_sent;
			while (ticks_sent - start_cnt < TICKS_PER_PHASE) begin
				if ($urandom_range(99) < 75) begin
					// finish any running glitch or half-loaded word first
					while (seq_st != SQ_IDLE || cmd_mode != CM_IDLE)
						send_tick(pick_tick(40));
					if (glitch_delay > SHORT_MAX || $urandom_range(1))
						send_load(gps_pkg::CMD_LOAD_DELAY);
					if (glitch_width > SHORT_MAX || $urandom_range(1))
						send_load(gps_pkg::CMD_LOAD_PULSE);
					if (short_run_ok()) begin
						send_tick('{1'b1, gps_pkg::CMD_START, 1'($urandom)});
						while (seq_st != SQ_IDLE)
							send_tick(pick_tick(30));
					end
				end else begin
					repeat ($urandom_range(1, 8)) send_tick(pick_tick(50));
				end
			end
			while (seq_st != SQ_IDLE)
				send_tick(pick_tick(30));
		end

		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Run covered %0d ticks over %0d power-off settings, %0d glitch runs,",
			ticks_sent, cfg_writes, glitch_runs);
		$display("%0d bytes dropped while busy; %0d results checked, %0d mismatches.",
			bytes_dropped, checked, errors);
		if (errors == 0)
			$display("tb_glitch_pulse_sequencer: PASS");
		else
			$display("tb_glitch_pulse_sequencer: FAIL");
		$finish;
	end

endmodule
